// ===== rtl/core/tlb_page_translation_defines.svh =====
// assertion macros for the tlb page translation block
// used by the port checker; needs clk_i and rst_ni in the scope of each use
`ifndef TLB_PAGE_TRANSLATION_DEFINES_SVH
`define TLB_PAGE_TRANSLATION_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define TLBPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLBPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tlbpt_pkg.sv =====
// shared constants and control structs of the tlb page translation block
// no dependencies; imported by every module of the block
`default_nettype none

package tlbpt_pkg;

  localparam int unsigned TLB_ENTRIES_DEF = 16;
  localparam int unsigned PAGE_COUNT      = 256;
  localparam int unsigned OFFSET_BITS     = 8;
  localparam int unsigned VA_W            = 16;
  localparam int unsigned PAGE_W          = $clog2(PAGE_COUNT);
  localparam int unsigned FRAME_W         = 8;
  localparam int unsigned PA_W            = 16;
  localparam int unsigned AGE_W           = 16;
  localparam int unsigned FREE_CNT_W      = 9;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // sequencer to tlb entry unit
  typedef struct packed {
    logic start;   // begin a scan over all entries
    logic commit;  // fill an entry after a miss
    logic lru;     // replacement policy is lru
  } tlbpt_ctrl_t;

  // tlb entry unit back to the sequencer
  typedef struct packed {
    logic               done;  // set once the last entry has been scanned
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlbpt_stat_t;

  // sequencer to page table
  typedef struct packed {
    logic rd;     // latch page and read its frame
    logic alloc;  // map the page to the next free frame if unmapped
  } tlbpt_pt_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/tlb_page_translation.sv =====
// top level of the tlb page translation block: sequencer, config and result register
// depends on tlbpt_pkg, tlbpt_entries and tlbpt_page_table
//
//   channel   direction  handshake                   payload
//   cfg       in         cfg_valid_i / cfg_ready_o   cfg_replace_policy_i
//   in        in         in_valid_i / in_stall_o     virtual_address_i
//   out       out        out_valid_o / out_stall_i   tlb_hit_o page_fault_o
//                                                    frame_number_o physical_address_o
//
// an item is not taken until the one before it has left the sequencer, which scans all entries
// with the shared compare/age unit visiting one tlb entry per cycle
// the page table frame is read in the accept cycle and resolved after the scan
// a finished result sits in the output register; new items are taken while it waits
// a full output register held by out_stall_i holds the sequencer in its final step
// reset clears tlb valid bits, ages, mapped flags and the free frame counter at once
`default_nettype none

module tlb_page_translation #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_replace_policy_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tlbpt_pkg::VA_W-1:0]    virtual_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          tlb_hit_o,
  output logic                          page_fault_o,
  output logic [tlbpt_pkg::FRAME_W-1:0] frame_number_o,
  output logic [tlbpt_pkg::PA_W-1:0]    physical_address_o
);
  import tlbpt_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_RESOLVE = 2'd2;

  logic [1:0]             state_q, state_d;
  logic                   policy_q;
  logic [PAGE_W-1:0]      page_q;
  logic [OFFSET_BITS-1:0] offset_q;
  logic                   out_valid_q;
  logic                   hit_q;
  logic                   fault_q;
  logic [FRAME_W-1:0]     frame_q;
  logic [PA_W-1:0]        phys_q;

  logic                   accept;
  logic                   fire;
  logic [PAGE_W-1:0]      in_page;
  logic [FRAME_W-1:0]     res_frame;
  logic                   pt_mapped;
  logic [FRAME_W-1:0]     pt_frame;
  tlbpt_ctrl_t            tlb_ctrl;
  tlbpt_stat_t            tlb_stat;
  tlbpt_pt_ctrl_t         pt_ctrl;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign in_page     = virtual_address_i[OFFSET_BITS +: PAGE_W];
  // result register free or being emptied this cycle
  assign fire        = (state_q == ST_RESOLVE) && (!out_valid_q || !out_stall_i);
  assign res_frame   = tlb_stat.hit ? tlb_stat.frame : pt_frame;

  assign tlb_ctrl.start  = accept;
  assign tlb_ctrl.commit = fire && !tlb_stat.hit;
  assign tlb_ctrl.lru    = policy_q;
  assign pt_ctrl.rd      = accept;
  assign pt_ctrl.alloc   = fire && !tlb_stat.hit;

  tlbpt_entries #(
    .TLB_ENTRIES(TLB_ENTRIES)
  ) u_entries (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (tlb_ctrl),
    .page_i  (page_q),
    .frame_i (pt_frame),
    .stat_o  (tlb_stat)
  );

  tlbpt_page_table u_page_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (pt_ctrl),
    .page_i   (in_page),
    .mapped_o (pt_mapped),
    .frame_o  (pt_frame)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tlb_stat.done) begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_replace_policy_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q   <= in_page;
      offset_q <= virtual_address_i[OFFSET_BITS-1:0];
    end
    if (fire) begin
      hit_q   <= tlb_stat.hit;
      fault_q <= !tlb_stat.hit && !pt_mapped;
      frame_q <= res_frame;
      phys_q  <= {res_frame, offset_q};
    end
  end

  assign out_valid_o        = out_valid_q;
  assign tlb_hit_o          = hit_q;
  assign page_fault_o       = fault_q;
  assign frame_number_o     = frame_q;
  assign physical_address_o = phys_q;

endmodule

`default_nettype wire

// ===== rtl/core/tlbpt_entries.sv =====
// tlb entry store with one shared compare/age unit stepping over the entries
// depends on tlbpt_pkg
`default_nettype none

module tlbpt_entries #(
  parameter int unsigned TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tlbpt_pkg::tlbpt_ctrl_t         ctrl_i,
  input  logic [tlbpt_pkg::PAGE_W-1:0]   page_i,
  input  logic [tlbpt_pkg::FRAME_W-1:0]  frame_i,
  output tlbpt_pkg::tlbpt_stat_t         stat_o
);
  import tlbpt_pkg::*;

  localparam int unsigned IdxW = $clog2(TLB_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TLB_ENTRIES - 1);

  logic [TLB_ENTRIES-1:0] valid_q;
  logic [PAGE_W-1:0]      page_q  [TLB_ENTRIES];
  logic [FRAME_W-1:0]     frame_q [TLB_ENTRIES];
  logic [AGE_W-1:0]       age_q   [TLB_ENTRIES];

  logic               scan_q;
  logic               done_q;
  logic [IdxW-1:0]    idx_q;
  logic               hit_q;
  logic [FRAME_W-1:0] hit_frame_q;
  logic               free_found_q;
  logic [IdxW-1:0]    free_slot_q;
  logic [IdxW-1:0]    victim_q;
  logic [AGE_W-1:0]   best_age_q;
  logic [IdxW-1:0]    fifo_ptr_q;

  logic               cur_valid;
  logic               cur_match;
  logic [AGE_W-1:0]   new_age;
  logic [IdxW-1:0]    fill_slot;

  assign cur_valid = valid_q[idx_q];
  // first matching entry only
  assign cur_match = scan_q && cur_valid && (page_q[idx_q] == page_i) && !hit_q;

  always_comb begin
    if (cur_match) begin
      new_age = '0;
    end else if (age_q[idx_q] == AGE_MAX) begin
      new_age = age_q[idx_q];
    end else begin
      new_age = age_q[idx_q] + AGE_W'(1);
    end
  end

  always_comb begin
    if (!ctrl_i.lru) begin
      fill_slot = fifo_ptr_q;
    end else if (free_found_q) begin
      fill_slot = free_slot_q;
    end else begin
      fill_slot = victim_q;
    end
  end

  // scan sequencing and running results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q       <= 1'b0;
      done_q       <= 1'b0;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      fifo_ptr_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        scan_q       <= 1'b1;
        idx_q        <= '0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else if (scan_q) begin
        if (cur_match) begin
          hit_q <= 1'b1;
        end
        if (!cur_valid && !free_found_q) begin
          free_found_q <= 1'b1;
        end
        if (idx_q == LastIdx) begin
          scan_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          idx_q <= idx_q + IdxW'(1);
        end
      end
      if (ctrl_i.commit && !ctrl_i.lru) begin
        fifo_ptr_q <= (fifo_ptr_q == LastIdx) ? '0 : fifo_ptr_q + IdxW'(1);
      end
    end
  end

  // payload of the scan, no reset needed
  always_ff @(posedge clk_i) begin
    if (scan_q) begin
      if (cur_match) begin
        hit_frame_q <= frame_q[idx_q];
      end
      if (!cur_valid && !free_found_q) begin
        free_slot_q <= idx_q;
      end
      // oldest entry wins, lowest index on ties
      if (idx_q == '0 || new_age > best_age_q) begin
        victim_q   <= idx_q;
        best_age_q <= new_age;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      if (scan_q && ctrl_i.lru && cur_valid) begin
        age_q[idx_q] <= new_age;
      end
      if (ctrl_i.commit) begin
        valid_q[fill_slot] <= 1'b1;
        age_q[fill_slot]   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      page_q[fill_slot]  <= page_i;
      frame_q[fill_slot] <= frame_i;
    end
  end

  assign stat_o.done  = done_q;
  assign stat_o.hit   = hit_q;
  assign stat_o.frame = hit_frame_q;

endmodule

`default_nettype wire

// ===== rtl/core/tlbpt_page_table.sv =====
// page table: mapped flags in flops, frame numbers in a memory, free frame counter
// depends on tlbpt_pkg
`default_nettype none

module tlbpt_page_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tlbpt_pkg::tlbpt_pt_ctrl_t      ctrl_i,
  input  logic [tlbpt_pkg::PAGE_W-1:0]   page_i,
  output logic                           mapped_o,
  output logic [tlbpt_pkg::FRAME_W-1:0]  frame_o
);
  import tlbpt_pkg::*;

  logic [PAGE_COUNT-1:0]   mapped_q;
  logic [FRAME_W-1:0]      mem [PAGE_COUNT];
  logic [FRAME_W-1:0]      rdata_q;
  logic [PAGE_W-1:0]       page_q;
  logic [FREE_CNT_W-1:0]   free_cnt_q;
  logic                    do_alloc;

  assign mapped_o = mapped_q[page_q];
  assign frame_o  = mapped_o ? rdata_q : free_cnt_q[FRAME_W-1:0];
  assign do_alloc = ctrl_i.alloc && !mapped_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapped_q   <= '0;
      free_cnt_q <= '0;
    end else if (do_alloc) begin
      mapped_q[page_q] <= 1'b1;
      free_cnt_q       <= free_cnt_q + FREE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_alloc) begin
      mem[page_q] <= free_cnt_q[FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rdata_q <= mem[page_i];
      page_q  <= page_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tlbpt_checker.sv =====
// port-level checker for the tlb page translation block, bound to the top level
// depends on tlbpt_pkg and tlb_page_translation_defines.svh
`default_nettype none

`include "tlb_page_translation_defines.svh"

module tlbpt_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic                          cfg_replace_policy_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [tlbpt_pkg::VA_W-1:0]    virtual_address_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic                          tlb_hit_o,
  input  logic                          page_fault_o,
  input  logic [tlbpt_pkg::FRAME_W-1:0] frame_number_o,
  input  logic [tlbpt_pkg::PA_W-1:0]    physical_address_o
);
  import tlbpt_pkg::*;

  logic in_accept;
  logic out_held;
  logic unused_ok;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_held  = out_valid_o && out_stall_i;
  assign unused_ok = cfg_valid_i ^ cfg_ready_o ^ cfg_replace_policy_i ^ (^virtual_address_i);

  // a hit never allocates a frame
  `TLBPT_ASSERT_NOW(a_hit_no_fault, out_valid_o, !(tlb_hit_o && page_fault_o), "hit with fault")

  // frame field and upper address bits come from the same frame
  `TLBPT_ASSERT_NOW(a_frame_in_addr, out_valid_o,
    physical_address_o[PA_W-1:OFFSET_BITS] == frame_number_o, "address frame mismatch")

  // one item at a time: busy right after taking an item
  `TLBPT_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall_o, "item taken twice in a row")

  // a held result stays put
  `TLBPT_ASSERT_NEXT(a_out_hold, out_held,
    out_valid_o && $stable(frame_number_o) && $stable(physical_address_o) &&
    $stable(tlb_hit_o) && $stable(page_fault_o), "held result changed")

endmodule

bind tlb_page_translation tlbpt_checker u_tlbpt_checker (.*);

`default_nettype wire

// ===== verif/tb_tlb_page_translation.sv =====
`timescale 1ns / 100ps
// testbench for tlb_page_translation: a directed address table, then random address streams
// under fifo and lru refill, each result checked against its typed row or an in-bench translation predictor
// depends on tlbpt_pkg and the rtl of the block only

module tb_tlb_page_translation;
  import tlbpt_pkg::*;

  localparam int unsigned SLOTS          = TLB_ENTRIES_DEF;
  localparam int unsigned CYCLE_LIMIT    = 200_000;
  localparam int unsigned RAND_PER_PHASE = 164;
  localparam int unsigned HOT_N          = 20;
  // hits on one page while every other lru age keeps climbing
  localparam int unsigned HOT_HITS       = 20;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef enum logic {POL_FIFO = 1'b0, POL_LRU = 1'b1} policy_e;

  typedef struct packed {
    logic [VA_W-1:0]    va;
    logic               hit;
    logic               fault;
    logic [FRAME_W-1:0] frame;
    logic [PA_W-1:0]    pa;
  } xlat_t;

  typedef struct packed {
    logic [VA_W-1:0]    va;
    policy_e            pol;
    logic               known;
    logic               hit;
    logic               fault;
    logic [FRAME_W-1:0] frame;
  } dir_row_t;

  localparam int unsigned DIR_N = 24;

  // typed rows: cold start, offset extremes, fifo fill and wrap, page table
  // hit after eviction, lru refill over a full tlb with tied ages
  dir_row_t dir_tab [DIR_N] = '{
    '{16'h0000, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h00},
    '{16'hFFFF, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h01},
    '{16'h00FF, POL_FIFO, 1'b1, 1'b1, 1'b0, 8'h00},
    '{16'hFF00, POL_FIFO, 1'b1, 1'b1, 1'b0, 8'h01},
    '{16'h8055, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h02},
    '{16'h10A0, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h03},
    '{16'h1101, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h04},
    '{16'h12FE, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h05},
    '{16'h1333, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h06},
    '{16'h1480, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h07},
    '{16'h157F, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h08},
    '{16'h1600, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h09},
    '{16'h17FF, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h0A},
    '{16'h1855, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h0B},
    '{16'h19AA, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h0C},
    '{16'h1A0F, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h0D},
    '{16'h1BF0, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h0E},
    '{16'h1C3C, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h0F},
    '{16'h7E3C, POL_FIFO, 1'b1, 1'b0, 1'b1, 8'h10},
    '{16'h0042, POL_FIFO, 1'b1, 1'b0, 1'b0, 8'h00},
    '{16'hFF80, POL_LRU,  1'b1, 1'b0, 1'b0, 8'h01},
    '{16'h7E01, POL_LRU,  1'b0, 1'b0, 1'b0, 8'h00},
    '{16'h1234, POL_LRU,  1'b0, 1'b0, 1'b0, 8'h00},
    '{16'h0000, POL_LRU,  1'b1, 1'b0, 1'b0, 8'h00}
  };

  logic                clk_i                = 1'b0;
  logic                rst_ni               = 1'b0;
  logic                cfg_valid_i          = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_replace_policy_i = 1'b0;
  logic                in_valid_i           = 1'b0;
  logic                in_stall_o;
  logic [VA_W-1:0]     virtual_address_i    = '0;
  logic                out_valid_o;
  logic                out_stall_i          = 1'b0;
  logic                tlb_hit_o;
  logic                page_fault_o;
  logic [FRAME_W-1:0]  frame_number_o;
  logic [PA_W-1:0]     physical_address_o;

  // predictor state
  logic                     tv     [SLOTS];
  logic [PAGE_W-1:0]        tpage  [SLOTS];
  logic [FRAME_W-1:0]       tframe [SLOTS];
  logic [AGE_W-1:0]         tage   [SLOTS];
  logic [$clog2(SLOTS)-1:0] fifo_ptr;
  logic                     pmap   [PAGE_COUNT];
  logic [FRAME_W-1:0]       pframe [PAGE_COUNT];
  logic [FREE_CNT_W-1:0]    free_frame;
  policy_e                  pol;

  xlat_t             xlat_q [$];
  xlat_t             mon_want;
  logic [PAGE_W-1:0] hot_pages [HOT_N];
  int unsigned       send_pct, recv_pct;
  int unsigned       fails, n_sent, n_results, n_hits, n_faults, cycle_cnt;

  tlb_page_translation DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_replace_policy_i (cfg_replace_policy_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .virtual_address_i    (virtual_address_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .tlb_hit_o            (tlb_hit_o),
    .page_fault_o         (page_fault_o),
    .frame_number_o       (frame_number_o),
    .physical_address_o   (physical_address_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void fill_slot(input int slot, input logic [PAGE_W-1:0] pg,
                                    input logic [FRAME_W-1:0] fr);
    tv[slot]     = 1'b1;
    tpage[slot]  = pg;
    tframe[slot] = fr;
    tage[slot]   = '0;
  endfunction

  // translate one address and advance the tlb, page table and frame counter
  function automatic xlat_t translate(input logic [VA_W-1:0] va);
    logic [PAGE_W-1:0] pg;
    xlat_t             r;
    int                hit_at, free_at, victim;
    pg     = va[OFFSET_BITS +: PAGE_W];
    r      = '0;
    hit_at = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit_at < 0 && tv[i] && tpage[i] == pg) begin
        hit_at  = i;
        r.frame = tframe[i];
      end
    end
    if (hit_at < 0) begin
      if (pmap[pg]) begin
        r.frame = pframe[pg];
      end else begin
        r.fault    = 1'b1;
        r.frame    = free_frame[FRAME_W-1:0];
        pmap[pg]   = 1'b1;
        pframe[pg] = r.frame;
        free_frame = free_frame + 1'b1;
      end
    end
    r.hit = (hit_at >= 0);
    if (pol == POL_FIFO) begin
      if (hit_at < 0) begin
        fill_slot(fifo_ptr, pg, r.frame);
        fifo_ptr = fifo_ptr + 1'b1;
      end
    end else begin
      free_at = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!tv[i]) begin
          if (free_at < 0) free_at = i;
        end else if (i == hit_at) begin
          tage[i] = '0;
        end else if (tage[i] != AGE_MAX) begin
          tage[i] = tage[i] + 1'b1;
        end
      end
      if (hit_at < 0) begin
        if (free_at >= 0) begin
          victim = free_at;
        end else begin
          // oldest entry, lowest index on ties
          victim = 0;
          for (int i = 1; i < SLOTS; i++) begin
            if (tage[i] > tage[victim]) victim = i;
          end
        end
        fill_slot(victim, pg, r.frame);
      end
    end
    r.va = va;
    r.pa = {r.frame, va[OFFSET_BITS-1:0]};
    return r;
  endfunction

  function automatic logic [VA_W-1:0] pick_va();
    logic [PAGE_W-1:0]      pg;
    logic [OFFSET_BITS-1:0] off;
    // mostly a working set a little larger than the tlb, so hits and refills mix
    if ($urandom_range(99) < 75) pg = hot_pages[$urandom_range(HOT_N-1)];
    else pg = PAGE_W'($urandom);
    off = OFFSET_BITS'($urandom);
    return {pg, off};
  endfunction

  function automatic void refresh_hot(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      hot_pages[$urandom_range(HOT_N-1)] = PAGE_W'($urandom);
    end
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_va(input logic [VA_W-1:0] va, input logic typed_ok, input xlat_t typed);
    xlat_t pred;
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    virtual_address_i <= va;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = translate(va);
    xlat_q.push_back(typed_ok ? typed : pred);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (xlat_q.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_policy(input policy_e p);
    cfg_valid_i          <= 1'b1;
    cfg_replace_policy_i <= p;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    pol = p;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n, input logic flip);
    for (int unsigned k = 0; k < n; k++) begin
      if (k == 0) refresh_hot(HOT_N * 2);
      else if (k % 60 == 0) refresh_hot(4);
      // halfway the sender holds off until the block has emptied
      if (k == n / 2) begin
        wait_drained();
        if (flip) write_policy(pol == POL_FIFO ? POL_LRU : POL_FIFO);
      end
      send_va(pick_va(), 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, xlat_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (xlat_q.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("unexpected result: hit=%b fault=%b frame=%h pa=%h",
                   tlb_hit_o, page_fault_o, frame_number_o, physical_address_o);
      end else begin
        mon_want = xlat_q.pop_front();
        n_results++;
        n_hits   += mon_want.hit;
        n_faults += mon_want.fault;
        if (tlb_hit_o !== mon_want.hit || page_fault_o !== mon_want.fault ||
            frame_number_o !== mon_want.frame || physical_address_o !== mon_want.pa) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("va %h: expected hit=%b fault=%b frame=%h pa=%h, got %b %b %h %h",
                     mon_want.va, mon_want.hit, mon_want.fault, mon_want.frame, mon_want.pa,
                     tlb_hit_o, page_fault_o, frame_number_o, physical_address_o);
        end
      end
    end
  end

  initial begin
    xlat_t typed;
    for (int i = 0; i < SLOTS; i++) begin
      tv[i]   = 1'b0;
      tage[i] = '0;
    end
    for (int i = 0; i < PAGE_COUNT; i++) pmap[i] = 1'b0;
    for (int i = 0; i < HOT_N; i++) hot_pages[i] = PAGE_W'($urandom);
    fifo_ptr   = '0;
    free_frame = '0;
    pol        = POL_FIFO;
    send_pct   = 37;
    recv_pct   = 46;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < DIR_N; k++) begin
      if (dir_tab[k].pol != pol) begin
        wait_drained();
        write_policy(dir_tab[k].pol);
      end
      typed.va    = dir_tab[k].va;
      typed.hit   = dir_tab[k].hit;
      typed.fault = dir_tab[k].fault;
      typed.frame = dir_tab[k].frame;
      typed.pa    = {dir_tab[k].frame, dir_tab[k].va[OFFSET_BITS-1:0]};
      send_va(dir_tab[k].va, dir_tab[k].known, typed);
    end
    wait_drained();
    write_policy(POL_FIFO);
    run_random(RAND_PER_PHASE, 1'b0);

    wait_drained();
    send_pct = 46;
    recv_pct = 37;
    write_policy(POL_LRU);
    run_random(RAND_PER_PHASE, 1'b0);

    wait_drained();
    send_pct = 0;
    recv_pct = 0;
    write_policy(POL_FIFO);
    run_random(RAND_PER_PHASE, 1'b1);

    // lru with a full tlb: keep one page hot while the other entries age,
    // then misses must evict the oldest entries
    wait_drained();
    write_policy(POL_LRU);
    for (int k = 0; k < HOT_HITS; k++) begin
      send_va({PAGE_W'(0), OFFSET_BITS'($urandom)}, 1'b0, '0);
    end
    for (int k = 0; k < 12; k++) begin
      send_va({PAGE_W'($urandom_range(255, 1)), OFFSET_BITS'($urandom)}, 1'b0, '0);
    end

    wait_drained();
    repeat (SLOTS + 8) @(posedge clk_i);
    $display("%0d addresses translated, %0d results checked: %0d tlb hits, %0d page faults",
             n_sent, n_results, n_hits, n_faults);
    $display("fifo and lru refill, policy changes over live entries, lru eviction around a hot page");
    if (fails == 0 && xlat_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results never seen", fails, xlat_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/tlbpt_pkg.sv
rtl/core/tlbpt_entries.sv
rtl/core/tlbpt_page_table.sv
rtl/core/tlb_page_translation.sv
rtl/core/tlbpt_checker.sv
verif/tb_tlb_page_translation.sv
